// ----- hw/rtl/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants for the sphere frustum cull core.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

  localparam int unsigned NumPlanesDef = 6;

  typedef enum logic [1:0] {
    OP_LOAD_PLANE = 2'd0,
    OP_LOAD_ROW   = 2'd1,
    OP_CULL       = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CTR,
    ST_CSAT,
    ST_SQ,
    ST_SQMAX,
    ST_SQRT,
    ST_RAD,
    ST_RSAT,
    ST_PLANE,
    ST_PCMP,
    ST_SHAD,
    ST_SCMP,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/sphere_frustum_cull_with_shadow_core.sv -----
// ----------------------------------------------------------------------------
// sphere_frustum_cull_with_shadow_core
// Q16.16 bounding-sphere frustum cull with shadow point, one shared multiplier.
// ----------------------------------------------------------------------------
// Channel | dir | tdata fields (low bit first)                      | tuser
// s_axis  | in  | slot[2:0], vec_x, vec_y, vec_z, scalar_w,          | operation
//         |     | shadow_x, shadow_y, shadow_z (227 bits -> 232)     |
// m_axis  | out | shadow_outside, ctr x, y, z, world_radius (128)    | culled
//
// A cull test runs through one 33x33 signed multiplier, one product per cycle:
// the centre, the squared lengths, a 32-step square root (two radicand bits a
// step), the radius, each plane tested and, where the sphere is outside a
// plane, the shadow point against that plane; then the result is loaded.
// The next item is taken only after the result has been accepted.
// s_axis_tready is high only when idle and the result register is empty.
// Reset clears control state only; plane and matrix stores stay undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_frustum_cull_with_shadow_core
  import sfc_pkg::*;
#(
  parameter int unsigned NUM_PLANES = NumPlanesDef
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // slot, vec_x, vec_y, vec_z, scalar_w, shadow_x, shadow_y, shadow_z, pad
  input  wire logic [231:0] s_axis_tdata,
  // operation
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // shadow_outside, world_center_x, _y, _z, world_radius
  output logic [127:0]      m_axis_tdata,
  // culled
  output logic              m_axis_tuser
);

  localparam int unsigned PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  // stores: plane x,y,z,d and matrix rows x,y,z
  logic signed [31:0] plane_q [NUM_PLANES][4];
  logic signed [31:0] row_q   [4][3];

  logic [2:0]         slot;
  logic signed [31:0] in_v [4];
  logic signed [31:0] in_s [3];
  assign slot    = s_axis_tdata[2:0];
  assign in_v[0] = s_axis_tdata[34:3];
  assign in_v[1] = s_axis_tdata[66:35];
  assign in_v[2] = s_axis_tdata[98:67];
  assign in_v[3] = s_axis_tdata[130:99];
  assign in_s[0] = s_axis_tdata[162:131];
  assign in_s[1] = s_axis_tdata[194:163];
  assign in_s[2] = s_axis_tdata[226:195];

  state_e state_q, state_d;
  logic signed [31:0] v_q [4];     // local centre, radius
  logic signed [31:0] sh_q [3];
  logic signed [31:0] ctr_q [3];
  logic [30:0]        rad_q;
  logic signed [49:0] acc_q;       // sum of three products
  logic [1:0]         i_q, j_q;    // outer / inner counters
  logic [PW-1:0]      p_q;
  logic signed [49:0] max_q;
  logic [5:0]         sq_n_q;
  logic [35:0]        rem_q;
  logic [31:0]        res_q;
  logic [63:0]        rad_src_q;   // radicand, shifted out two bits a step
  logic               culled_q, shadow_q;
  logic               out_v_q;

  // shared multiplier: 33x33 signed, truncate toward zero, >>16
  logic signed [32:0] ma, mb;
  logic signed [65:0] prod;
  logic signed [49:0] qprod;
  logic               take;

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      ST_CTR: begin
        ma = 33'(v_q[j_q]);
        mb = 33'(row_q[j_q][i_q]);
      end
      ST_SQ: begin
        ma = 33'(row_q[i_q][j_q]);
        mb = 33'(row_q[i_q][j_q]);
      end
      ST_RAD: begin
        ma = 33'(v_q[3]);
        mb = $signed({1'b0, res_q});
      end
      ST_PLANE: begin
        ma = 33'(ctr_q[j_q]);
        mb = 33'(plane_q[p_q][j_q]);
      end
      ST_SHAD: begin
        ma = 33'(sh_q[j_q]);
        mb = 33'(plane_q[p_q][j_q]);
      end
      default: ;
    endcase
    prod  = ma * mb;
    qprod = 50'((prod + ((prod < 0) ? 66'sd65535 : 66'sd0)) >>> 16);
  end

  // sqrt step
  logic [35:0] rem_sh;
  logic [35:0] trial;
  always_comb begin
    rem_sh = {rem_q[33:0], rad_src_q[63:62]};
    trial  = {2'd0, res_q, 2'b01};
  end

  logic signed [49:0] pl_dist;
  assign pl_dist = acc_q - 50'(plane_q[p_q][3]);

  logic last_p;
  assign last_p = (32'(p_q) == NUM_PLANES - 1);

  assign s_axis_tready = (state_q == ST_IDLE) && !out_v_q;
  assign take = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (take && s_axis_tuser == OP_CULL) state_d = ST_CTR;
      ST_CTR:   if (j_q == 2'd2) state_d = ST_CSAT;
      ST_CSAT:  state_d = (i_q == 2'd2) ? ST_SQ : ST_CTR;
      ST_SQ:    if (j_q == 2'd2) state_d = ST_SQMAX;
      ST_SQMAX: state_d = (i_q == 2'd2) ? ST_SQRT : ST_SQ;
      ST_SQRT:  if (sq_n_q == 6'd32) state_d = ST_RAD;
      ST_RAD:   state_d = ST_RSAT;
      ST_RSAT:  state_d = ST_PLANE;
      ST_PLANE: if (j_q == 2'd2) state_d = ST_PCMP;
      ST_PCMP: begin
        if (pl_dist > $signed({19'd0, rad_q})) state_d = ST_SHAD;
        else if (last_p) state_d = ST_OUT;
        else state_d = ST_PLANE;
      end
      ST_SHAD:  if (j_q == 2'd2) state_d = ST_SCMP;
      ST_SCMP: begin
        if (pl_dist > $signed({19'd0, rad_q}) || last_p) state_d = ST_OUT;
        else state_d = ST_PLANE;
      end
      ST_OUT:   state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT) out_v_q <= 1'b1;
      else if (m_axis_tready) out_v_q <= 1'b0;
    end
  end

  // stores and datapath
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (s_axis_tuser == OP_LOAD_PLANE && 32'(slot) < NUM_PLANES) begin
        for (int k = 0; k < 4; k++) plane_q[slot[PW-1:0]][k] <= in_v[k];
      end
      if (s_axis_tuser == OP_LOAD_ROW && slot < 3'd4) begin
        for (int k = 0; k < 3; k++) row_q[slot[1:0]][k] <= in_v[k];
      end
      for (int k = 0; k < 4; k++) v_q[k] <= in_v[k];
      for (int k = 0; k < 3; k++) sh_q[k] <= in_s[k];
      i_q      <= '0;
      j_q      <= '0;
      acc_q    <= '0;
      max_q    <= '0;
      p_q      <= '0;
      culled_q <= 1'b0;
      shadow_q <= 1'b0;
    end
    unique case (state_q)
      ST_CTR, ST_SQ, ST_PLANE, ST_SHAD: begin
        acc_q <= acc_q + qprod;
        j_q   <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
      end
      ST_CSAT: begin
        if (acc_q + 50'(row_q[3][i_q]) > 50'sh07FFFFFFF)
          ctr_q[i_q] <= 32'h7FFFFFFF;
        else if (acc_q + 50'(row_q[3][i_q]) < -50'sh080000000)
          ctr_q[i_q] <= 32'h80000000;
        else
          ctr_q[i_q] <= 32'(acc_q + 50'(row_q[3][i_q]));
        acc_q <= '0;
        i_q   <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
      end
      ST_SQMAX: begin
        if (acc_q > max_q) max_q <= acc_q;
        acc_q <= '0;
        i_q   <= i_q + 2'd1;
        if (i_q == 2'd2) begin
          rad_src_q <= {((acc_q > max_q) ? acc_q[47:0] : max_q[47:0]), 16'd0};
          rem_q     <= '0;
          res_q     <= '0;
          sq_n_q    <= '0;
        end
      end
      ST_SQRT: begin
        if (sq_n_q != 6'd32) begin
          rad_src_q <= {rad_src_q[61:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_q <= rem_sh - trial;
            res_q <= {res_q[30:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            res_q <= {res_q[30:0], 1'b0};
          end
        end
        sq_n_q <= sq_n_q + 6'd1;
      end
      ST_RAD: acc_q <= (qprod > 50'sh7FFFFFFF) ? 50'sh7FFFFFFF :
                       ((qprod < 0) ? 50'sd0 : qprod);
      ST_RSAT: begin
        rad_q <= acc_q[30:0];
        acc_q <= '0;
      end
      ST_PCMP: begin
        acc_q <= '0;
        if (pl_dist > $signed({19'd0, rad_q})) culled_q <= 1'b1;
        else if (!last_p) p_q <= p_q + PW'(1);
      end
      ST_SCMP: begin
        acc_q <= '0;
        if (pl_dist > $signed({19'd0, rad_q})) shadow_q <= 1'b1;
        else if (!last_p) p_q <= p_q + PW'(1);
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = culled_q;
  assign m_axis_tdata  = {rad_q, ctr_q[2], ctr_q[1], ctr_q[0], shadow_q};

endmodule

`default_nettype wire
